/* design/assert_macros.svh */
// Assertion macros shared by the run encoder RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SGRE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies condition in the next.
`define SGRE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/sgre_pkg.sv */
// Types and constants for the sparse grid run encoder.
// No dependencies.
package sgre_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int Q_DEPTH    = 4;

    localparam logic [30:0] LEN_MAX = '1;

    typedef enum logic [1:0] {
        REG_BACKGROUND = 2'd0,
        REG_LAYERS     = 2'd1,
        REG_ROWS       = 2'd2,
        REG_COLS       = 2'd3
    } sgre_reg_t;

    typedef struct packed {
        logic [31:0] background_bits;
        logic [6:0]  layer_count;
        logic [12:0] row_count;
        logic [12:0] column_count;
    } sgre_cfg_t;

    typedef struct packed {
        logic [5:0]  run_layer;
        logic [11:0] run_row;
        logic [11:0] run_col;
        logic [31:0] run_value;
        logic [30:0] run_length;
        logic        grid_done;
    } sgre_run_t;

    // Up to two runs produced by one cell; first is taken before second.
    typedef struct packed {
        logic [1:0] count;
        sgre_run_t  first;
        sgre_run_t  second;
    } sgre_push_t;

endpackage

/* design/sgre_ifaces.sv */
// Valid/ready stream interfaces for grid cells and emitted runs.
// No dependencies.
interface sgre_cell_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_bits;

    modport source (output valid, output sample_bits, input ready);
    modport sink (input valid, input sample_bits, output ready);
endinterface

interface sgre_run_if;
    logic        valid;
    logic        ready;
    logic [5:0]  run_layer;
    logic [11:0] run_row;
    logic [11:0] run_col;
    logic [31:0] run_value;
    logic [30:0] run_length;
    logic        grid_done;

    modport source (output valid, output run_layer, output run_row, output run_col,
                    output run_value, output run_length, output grid_done, input ready);
    modport sink (input valid, input run_layer, input run_row, input run_col,
                  input run_value, input run_length, input grid_done, output ready);
endinterface

/* design/sgre_cfg_regs.sv */
// APB-style configuration registers of the run encoder.
// Depends on sgre_pkg.
module sgre_cfg_regs
    import sgre_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output sgre_cfg_t             cfg
);

    sgre_cfg_t cfg_reg;
    sgre_cfg_t cfg_next;
    sgre_reg_t reg_sel;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = sgre_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_BACKGROUND: cfg_next.background_bits = pwdata;
                REG_LAYERS:     cfg_next.layer_count     = pwdata[6:0];
                REG_ROWS:       cfg_next.row_count       = pwdata[12:0];
                REG_COLS:       cfg_next.column_count    = pwdata[12:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BACKGROUND: prdata = cfg_reg.background_bits;
            REG_LAYERS:     prdata = {25'd0, cfg_reg.layer_count};
            REG_ROWS:       prdata = {19'd0, cfg_reg.row_count};
            REG_COLS:       prdata = {19'd0, cfg_reg.column_count};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.background_bits <= 32'd0;
            cfg_reg.layer_count     <= 7'd1;
            cfg_reg.row_count       <= 13'd1;
            cfg_reg.column_count    <= 13'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/sgre_encoder.sv */
// Input register, coordinate counters and open-run state of the run encoder.
// Depends on sgre_pkg, sgre_ifaces and assert_macros.svh.
`include "assert_macros.svh"
module sgre_encoder
    import sgre_pkg::*;
#(
    parameter int MAX_LAYERS = 64,
    parameter int MAX_ROWS   = 4096,
    parameter int MAX_COLS   = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sgre_cfg_t  cfg,
    sgre_cell_if.sink  cells,
    input  logic       room,
    output sgre_push_t push
);

    localparam int LAYER_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int LN_W    = $clog2(MAX_LAYERS + 1);
    localparam int RN_W    = $clog2(MAX_ROWS + 1);
    localparam int CN_W    = $clog2(MAX_COLS + 1);

    logic               s_valid_reg;
    logic               s_valid_next;
    logic [31:0]        s_sample_reg;

    logic [LAYER_W-1:0] layer_pos_reg, layer_pos_next;
    logic [ROW_W-1:0]   row_pos_reg, row_pos_next;
    logic [COL_W-1:0]   col_pos_reg, col_pos_next;
    logic               run_open_reg, run_open_next;
    logic [31:0]        open_value_reg, open_value_next;
    logic [5:0]         open_layer_reg, open_layer_next;
    logic [11:0]        open_row_reg, open_row_next;
    logic [11:0]        open_col_reg, open_col_next;
    logic [30:0]        open_length_reg, open_length_next;

    logic [LN_W-1:0]    n_layers;
    logic [RN_W-1:0]    n_rows;
    logic [CN_W-1:0]    n_cols;
    logic               last_col, last_row, last_layer, last_cell;
    logic               fire;
    logic               cell_xfer;
    logic               is_bg, extend, close_run, open_after, flush;
    logic [31:0]        val_after;
    logic [5:0]         layer_after;
    logic [11:0]        row_after, col_after;
    logic [30:0]        len_after;
    sgre_run_t          closed_run, flushed_run;

    assign fire        = s_valid_reg && room;
    assign cells.ready = !s_valid_reg || room;
    assign cell_xfer   = cells.valid && cells.ready;

    // Zero count acts as one; counts above the maximum saturate.
    assign n_layers = (cfg.layer_count == 7'd0) ? LN_W'(1) :
                      (int'(cfg.layer_count) > MAX_LAYERS) ? LN_W'(MAX_LAYERS) :
                      LN_W'(cfg.layer_count);
    assign n_rows   = (cfg.row_count == 13'd0) ? RN_W'(1) :
                      (int'(cfg.row_count) > MAX_ROWS) ? RN_W'(MAX_ROWS) :
                      RN_W'(cfg.row_count);
    assign n_cols   = (cfg.column_count == 13'd0) ? CN_W'(1) :
                      (int'(cfg.column_count) > MAX_COLS) ? CN_W'(MAX_COLS) :
                      CN_W'(cfg.column_count);

    assign last_col   = (int'(col_pos_reg) + 1) >= int'(n_cols);
    assign last_row   = (int'(row_pos_reg) + 1) >= int'(n_rows);
    assign last_layer = (int'(layer_pos_reg) + 1) >= int'(n_layers);
    assign last_cell  = last_col && last_row && last_layer;

    assign is_bg      = (s_sample_reg == cfg.background_bits);
    assign extend     = !is_bg && run_open_reg && (s_sample_reg == open_value_reg);
    assign close_run  = run_open_reg && !extend;
    assign open_after = !is_bg;
    assign flush      = last_cell && open_after;

    always_comb
    begin
        val_after   = open_value_reg;
        layer_after = open_layer_reg;
        row_after   = open_row_reg;
        col_after   = open_col_reg;
        len_after   = open_length_reg;
        if (extend)
        begin
            if (open_length_reg != LEN_MAX)
            begin
                len_after = open_length_reg + 31'd1;
            end
        end
        else if (!is_bg)
        begin
            val_after   = s_sample_reg;
            layer_after = 6'(layer_pos_reg);
            row_after   = 12'(row_pos_reg);
            col_after   = 12'(col_pos_reg);
            len_after   = 31'd1;
        end
    end

    always_comb
    begin
        closed_run.run_layer  = open_layer_reg;
        closed_run.run_row    = open_row_reg;
        closed_run.run_col    = open_col_reg;
        closed_run.run_value  = open_value_reg;
        closed_run.run_length = open_length_reg;
        closed_run.grid_done  = last_cell && !open_after;

        flushed_run.run_layer  = layer_after;
        flushed_run.run_row    = row_after;
        flushed_run.run_col    = col_after;
        flushed_run.run_value  = val_after;
        flushed_run.run_length = len_after;
        flushed_run.grid_done  = 1'b1;

        push.first  = close_run ? closed_run : flushed_run;
        push.second = flushed_run;
        push.count  = fire ? ({1'b0, close_run} + {1'b0, flush}) : 2'd0;
    end

    always_comb
    begin
        s_valid_next     = s_valid_reg;
        layer_pos_next   = layer_pos_reg;
        row_pos_next     = row_pos_reg;
        col_pos_next     = col_pos_reg;
        run_open_next    = run_open_reg;
        open_value_next  = open_value_reg;
        open_layer_next  = open_layer_reg;
        open_row_next    = open_row_reg;
        open_col_next    = open_col_reg;
        open_length_next = open_length_reg;
        if (fire)
        begin
            s_valid_next     = 1'b0;
            run_open_next    = open_after && !last_cell;
            open_value_next  = val_after;
            open_layer_next  = layer_after;
            open_row_next    = row_after;
            open_col_next    = col_after;
            open_length_next = len_after;
            if (last_cell)
            begin
                layer_pos_next = '0;
                row_pos_next   = '0;
                col_pos_next   = '0;
            end
            else if (!last_col)
            begin
                col_pos_next = col_pos_reg + COL_W'(1);
            end
            else
            begin
                col_pos_next = '0;
                if (!last_row)
                begin
                    row_pos_next = row_pos_reg + ROW_W'(1);
                end
                else
                begin
                    row_pos_next   = '0;
                    layer_pos_next = layer_pos_reg + LAYER_W'(1);
                end
            end
        end
        if (cell_xfer)
        begin
            s_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            layer_pos_reg <= '0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            run_open_reg  <= 1'b0;
        end
        else
        begin
            s_valid_reg   <= s_valid_next;
            layer_pos_reg <= layer_pos_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            run_open_reg  <= run_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_xfer)
        begin
            s_sample_reg <= cells.sample_bits;
        end
        open_value_reg  <= open_value_next;
        open_layer_reg  <= open_layer_next;
        open_row_reg    <= open_row_next;
        open_col_reg    <= open_col_next;
        open_length_reg <= open_length_next;
    end

    `SGRE_ASSERT(a_two_runs_only_at_end, (push.count == 2'd2) |-> (fire && last_cell), "two runs from a cell that is not the last")
    `SGRE_ASSERT_NEXT(a_coords_wrap, fire && last_cell, (layer_pos_reg == '0) && (row_pos_reg == '0) && (col_pos_reg == '0), "coordinates did not wrap at grid end")
    `SGRE_ASSERT_NEXT(a_no_run_after_end, fire && last_cell, !run_open_reg, "run still open after grid end")

endmodule

/* design/sgre_out_queue.sv */
// Result queue of the run encoder: takes up to two runs a cycle, sends one.
// Depends on sgre_pkg, sgre_ifaces and assert_macros.svh.
`include "assert_macros.svh"
module sgre_out_queue
    import sgre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sgre_push_t push,
    output logic       room,
    sgre_run_if.source runs
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    sgre_run_t        q_reg [Q_DEPTH];
    sgre_run_t        head;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign head             = q_reg[rd_ptr_reg];
    assign runs.valid       = (count_reg != '0);
    assign runs.run_layer   = head.run_layer;
    assign runs.run_row     = head.run_row;
    assign runs.run_col     = head.run_col;
    assign runs.run_value   = head.run_value;
    assign runs.run_length  = head.run_length;
    assign runs.grid_done   = head.grid_done;
    assign pop              = runs.valid && runs.ready;

    // Room for two after this cycle's transfer out.
    assign room = (count_reg - CNT_W'(pop)) <= CNT_W'(Q_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    `SGRE_ASSERT(a_count_in_range, count_reg <= CNT_W'(Q_DEPTH), "queue count above depth")
    `SGRE_ASSERT(a_no_overflow, (push.count != 2'd0) |-> (int'(count_reg) - int'(pop) + int'(push.count) <= Q_DEPTH), "queue overflow")

endmodule

/* design/sparse_grid_run_encoder_core.sv */
// Top level of the sparse grid run encoder: config registers, encoder, result queue.
// Depends on sgre_pkg, sgre_ifaces, sgre_cfg_regs, sgre_encoder, sgre_out_queue.
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------------
//  cells    | in        | sample_bits
//  runs     | out       | run_layer, run_row, run_col, run_value, run_length,
//           |           | grid_done
//  apb      | in        | background_bits, layer_count, row_count, column_count
//
// One cell per cycle while the result queue has room; a run closed by a cell goes
// through the input register and then the result queue before it is valid on runs. The
// last cell of a grid may produce two runs; the 4-entry result queue holds them, and a
// cell is processed only when two entries are free after this cycle's transfer out.
// Reset clears coordinates, the open run and the queue; config returns to
// background 0 and all counts 1.
// A stalled runs channel backs up into cells through the input register.
module sparse_grid_run_encoder_core
    import sgre_pkg::*;
#(
    parameter int MAX_LAYERS = 64,
    parameter int MAX_ROWS   = 4096,
    parameter int MAX_COLS   = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    sgre_cell_if.sink             cells,
    sgre_run_if.source            runs
);

    sgre_cfg_t  cfg;
    sgre_push_t push;
    logic       room;

    sgre_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sgre_encoder #(
        .MAX_LAYERS (MAX_LAYERS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS)
    ) u_enc (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cells (cells),
        .room  (room),
        .push  (push)
    );

    sgre_out_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .runs  (runs)
    );

endmodule

/* sim/tb_sparse_grid_run_encoder_core.sv */
// Self-checking testbench for sparse_grid_run_encoder_core: streams grid cells, predicts runs.
// Depends on sgre_pkg, sgre_ifaces and the core; APB writes set background and grid sizes.
module tb_sparse_grid_run_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;
    import sgre_pkg::*;

    localparam int TB_MAX_LAYERS = 64;
    localparam int TB_MAX_ROWS   = 4096;
    localparam int TB_MAX_COLS   = 4096;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_CELLS  = 900;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    sgre_cell_if cells();
    sgre_run_if  runs();

    sparse_grid_run_encoder_core #(
        .MAX_LAYERS(TB_MAX_LAYERS),
        .MAX_ROWS  (TB_MAX_ROWS),
        .MAX_COLS  (TB_MAX_COLS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cells  (cells),
        .runs   (runs)
    );

    // register shadow
    logic [31:0] cfg_background = '0;
    logic [6:0]  cfg_layers     = 7'd1;
    logic [12:0] cfg_rows       = 13'd1;
    logic [12:0] cfg_cols       = 13'd1;

    // encoder shadow
    logic [5:0]  pos_layer     = '0;
    logic [11:0] pos_row       = '0;
    logic [11:0] pos_col       = '0;
    bit          run_active    = 1'b0;
    logic [31:0] active_value  = '0;
    logic [5:0]  active_layer  = '0;
    logic [11:0] active_row    = '0;
    logic [11:0] active_col    = '0;
    logic [30:0] active_length = '0;

    sgre_run_t   expected_runs[$];
    logic [31:0] palette[4];
    logic [31:0] last_sample   = '0;

    int unsigned errors        = 0;
    int unsigned cycle_count   = 0;
    bit          idle_on       = 1'b1;
    int unsigned stall_left    = 0;
    int unsigned hold_left     = 0;
    int unsigned hold_req      = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sparse_grid_run_encoder_core: FAIL");
            $finish;
        end
    end

    function automatic int unsigned eff_count(input int unsigned c, input int unsigned hi);
        if (c == 0)
            return 1;
        return (c > hi) ? hi : c;
    endfunction

    function automatic sgre_run_t current_run(input logic done);
        sgre_run_t r;
        r.run_layer  = active_layer;
        r.run_row    = active_row;
        r.run_col    = active_col;
        r.run_value  = active_value;
        r.run_length = active_length;
        r.grid_done  = done;
        return r;
    endfunction

    function automatic void encode_cell(input logic [31:0] v);
        sgre_run_t   closed[2];
        int unsigned n_layers;
        int unsigned n_rows;
        int unsigned n_cols;
        bit          end_col;
        bit          end_row;
        bit          end_layer;
        int          n;
        n_layers  = eff_count(cfg_layers, TB_MAX_LAYERS);
        n_rows    = eff_count(cfg_rows, TB_MAX_ROWS);
        n_cols    = eff_count(cfg_cols, TB_MAX_COLS);
        end_col   = (32'(pos_col) + 1) >= n_cols;
        end_row   = (32'(pos_row) + 1) >= n_rows;
        end_layer = (32'(pos_layer) + 1) >= n_layers;
        n = 0;
        if (v != cfg_background)
        begin
            if (run_active && v == active_value)
            begin
                if (active_length != LEN_MAX)
                    active_length++;
            end
            else
            begin
                if (run_active)
                begin
                    closed[n] = current_run(1'b0);
                    n++;
                end
                run_active    = 1'b1;
                active_value  = v;
                active_layer  = pos_layer;
                active_row    = pos_row;
                active_col    = pos_col;
                active_length = 31'd1;
            end
        end
        else if (run_active)
        begin
            closed[n] = current_run(1'b0);
            n++;
            run_active    = 1'b0;
            active_length = '0;
        end
        if (end_col && end_row && end_layer)
        begin
            if (run_active)
            begin
                closed[n] = current_run(1'b1);
                n++;
                run_active    = 1'b0;
                active_length = '0;
            end
            else if (n > 0)
                closed[n-1].grid_done = 1'b1;
            pos_layer = '0;
            pos_row   = '0;
            pos_col   = '0;
        end
        else if (!end_col)
            pos_col++;
        else
        begin
            pos_col = '0;
            if (!end_row)
                pos_row++;
            else
            begin
                pos_row = '0;
                pos_layer++;
            end
        end
        for (int i = 0; i < n; i++)
            expected_runs.insert(expected_runs.size(), closed[i]);
    endfunction

    function automatic bit field_ok(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic check_run();
        sgre_run_t e;
        bit        ok;
        if (expected_runs.size() == 0)
        begin
            $display("%0t: unexpected run, expected none, actual %0d/%0d/%0d %0h len %0d done %0b",
                     $time, runs.run_layer, runs.run_row, runs.run_col, runs.run_value,
                     runs.run_length, runs.grid_done);
            errors++;
            return;
        end
        e  = expected_runs.pop_front();
        ok = 1'b1;
        ok &= field_ok("run_layer", 32'(e.run_layer), 32'(runs.run_layer));
        ok &= field_ok("run_row", 32'(e.run_row), 32'(runs.run_row));
        ok &= field_ok("run_col", 32'(e.run_col), 32'(runs.run_col));
        ok &= field_ok("run_value", e.run_value, runs.run_value);
        ok &= field_ok("run_length", 32'(e.run_length), 32'(runs.run_length));
        ok &= field_ok("grid_done", 32'(e.grid_done), 32'(runs.grid_done));
        if (!ok)
            errors++;
    endtask

    // run receiver and checker
    initial
    begin
        runs.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && runs.valid && runs.ready)
                check_run();
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                runs.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                runs.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                runs.ready <= 1'b0;
            end
            else
                runs.ready <= 1'b1;
        end
    end

    task automatic send_cell(input logic [31:0] v);
        if (idle_on && $urandom_range(0, 15) == 0)
        begin
            cells.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        cells.valid       <= 1'b1;
        cells.sample_bits <= v;
        do
            @(posedge clk);
        while (!cells.ready);
        encode_cell(v);
        last_sample = v;
    endtask

    task automatic cells_stop();
        cells.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        cells_stop();
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input sgre_reg_t r, input logic [31:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(r));
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (r)
            REG_BACKGROUND: cfg_background = d;
            REG_LAYERS:     cfg_layers     = d[6:0];
            REG_ROWS:       cfg_rows       = d[12:0];
            REG_COLS:       cfg_cols       = d[12:0];
            default:        ;
        endcase
    endtask

    task automatic configure(input logic [31:0] bg, input int unsigned layers,
                             input int unsigned rows, input int unsigned cols);
        drain();
        apb_write(REG_BACKGROUND, bg);
        apb_write(REG_LAYERS, 32'(layers));
        apb_write(REG_ROWS, 32'(rows));
        apb_write(REG_COLS, 32'(cols));
        palette[0] = $urandom();
        palette[1] = ~bg;
        palette[2] = bg ^ 32'd1;
        palette[3] = $urandom();
    endtask

    function automatic logic [31:0] pick_sample();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return cfg_background;
        if (sel < 65)
            return last_sample;
        if (sel < 90)
            return palette[$urandom_range(0, 3)];
        return $urandom();
    endfunction

    task automatic send_random_cells(input int unsigned n);
        repeat (n) send_cell(pick_sample());
    endtask

    task automatic test_directed_runs();
        logic [31:0] grid_edges[8] = '{32'd5, 32'd5, 32'd5, 32'd0,
                                       32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
        logic [31:0] grid_double[8] = '{32'd7, 32'd7, 32'd7, 32'd7,
                                        32'd7, 32'd7, 32'd7, 32'd9};
        logic [31:0] grid_bg_end[8] = '{32'd8, 32'd8, 32'd8, 32'd8,
                                        32'd8, 32'd8, 32'd8, 32'hFFFF_FFFF};
        // reset sizes: every cell is a whole grid
        send_cell(32'd0);
        send_cell(32'hFFFF_FFFF);
        configure(32'hFFFF_FFFF, 2, 2, 2);
        foreach (grid_edges[i])
            send_cell(grid_edges[i]);
        foreach (grid_double[i])
            send_cell(grid_double[i]);
        foreach (grid_bg_end[i])
            send_cell(grid_bg_end[i]);
    endtask

    task automatic test_count_limits();
        configure(32'd0, 0, 0, 0);
        send_cell(32'd3);
        send_cell(32'd3);
        send_cell(32'd0);
        configure($urandom(), 127, 1, 1);
        send_random_cells(66);
        configure(32'd0, 64, 4096, 4096);
        send_random_cells(20);
        // shrink columns while the position is past the new size
        configure(32'd0, 1, 4, 8);
        send_random_cells(13);
        configure(32'd0, 1, 4, 3);
        send_random_cells(10);
    endtask

    task automatic test_backpressure();
        configure(32'd0, 64, 4096, 4096);
        hold_req = 400;
        for (int i = 1; i <= 48; i++)
            send_cell(32'(i));
        drain();
    endtask

    task automatic test_sender_pause();
        configure(32'hFFFF_FFFF, 2, 3, 5);
        send_random_cells(30);
        drain();
        send_random_cells(30);
    endtask

    task automatic test_random_grids();
        int unsigned sent;
        int unsigned n;
        int unsigned sel;
        logic [31:0] bg;
        int unsigned layers;
        int unsigned rows;
        int unsigned cols;
        sent = 0;
        while (sent < RANDOM_CELLS)
        begin
            idle_on = (sent < RANDOM_CELLS - 150);
            sel = $urandom_range(0, 9);
            bg = (sel == 0) ? 32'd0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom();
            sel = $urandom_range(0, 19);
            layers = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(65, 127) :
                     (sel == 2) ? 64 : $urandom_range(1, 4);
            sel = $urandom_range(0, 19);
            rows = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(4097, 8191) :
                   (sel == 2) ? 4096 : $urandom_range(1, 6);
            sel = $urandom_range(0, 19);
            cols = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(4097, 8191) :
                   (sel == 2) ? 4096 : $urandom_range(1, 8);
            configure(bg, layers, rows, cols);
            n = $urandom_range(5, 60);
            send_random_cells(n);
            sent += n;
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        cells.valid       <= 1'b0;
        cells.sample_bits <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_runs();
        test_count_limits();
        test_backpressure();
        test_sender_pause();
        test_random_grids();

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_sparse_grid_run_encoder_core: PASS");
        else
            $display("tb_sparse_grid_run_encoder_core: FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/sgre_pkg.sv
design/sgre_ifaces.sv
design/sgre_cfg_regs.sv
design/sgre_encoder.sv
design/sgre_out_queue.sv
design/sparse_grid_run_encoder_core.sv
sim/tb_sparse_grid_run_encoder_core.sv
